// ----- hdl/erg_pkg.sv -----
// Shared constants, types and the arctangent table of the Euler rate integrator.
`default_nettype none
package erg_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int STAGE_CAP = 24;
  localparam int NST = (CORDIC_STAGES < STAGE_CAP) ? CORDIC_STAGES : STAGE_CAP;

  localparam logic REG_YAW_SIGN = 1'b0;

  localparam int XW = 27;
  localparam int ZW = 34;
  localparam int DW = 26;
  localparam int QW = 35;
  localparam int NW = 50;
  localparam int AW = 34;
  localparam int TW = 36;
  localparam int PW = 46;

  localparam logic signed [XW-1:0] GAIN_Q24 = 27'sd10188013;
  localparam logic signed [XW-1:0] DEG360_Q16 = 27'sd23592960;
  localparam logic signed [XW-1:0] DEG180_Q16 = 27'sd11796480;
  localparam logic signed [XW-1:0] DEG90_Q16 = 27'sd5898240;
  localparam logic [DW-1:0] COS_EPS_Q24 = 26'd16777;
  localparam logic [NW-1:0] SEC_NUM = 50'd281474976710656;

  typedef struct packed {
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
    logic signed [31:0] p;
    logic signed [31:0] q;
    logic signed [32:0] r;
    logic [23:0] dt;
  } erg_side_t;

  typedef struct packed {
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
    logic signed [31:0] p;
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] b;
    logic [23:0] dt;
  } erg_kin_t;

  function automatic logic signed [ZW-1:0] atan_q24(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 34'sd754974720;
      1: v = 34'sd445687602;
      2: v = 34'sd235489088;
      3: v = 34'sd119537938;
      4: v = 34'sd60000934;
      5: v = 34'sd30029717;
      6: v = 34'sd15018523;
      7: v = 34'sd7509720;
      8: v = 34'sd3754917;
      9: v = 34'sd1877466;
      10: v = 34'sd938734;
      11: v = 34'sd469367;
      12: v = 34'sd234684;
      13: v = 34'sd117342;
      14: v = 34'sd58671;
      15: v = 34'sd29335;
      16: v = 34'sd14668;
      17: v = 34'sd7334;
      18: v = 34'sd3667;
      19: v = 34'sd1833;
      20: v = 34'sd917;
      21: v = 34'sd458;
      22: v = 34'sd229;
      23: v = 34'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/erg_cordic.sv -----
// Pipelined angle reduction and two-lane CORDIC for sine and cosine of roll and pitch.
`default_nettype none
module erg_cordic (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  erg_pkg::erg_side_t             in_side,
  output logic                           out_vld,
  output logic signed [erg_pkg::XW-1:0]  sin_roll,
  output logic signed [erg_pkg::XW-1:0]  cos_roll,
  output logic signed [erg_pkg::XW-1:0]  sin_pitch,
  output logic signed [erg_pkg::XW-1:0]  cos_pitch,
  output erg_pkg::erg_side_t             out_side
);
  import erg_pkg::*;

  logic signed [31:0] ang [2];
  logic [15:0] u_c [2];
  logic [31:0] prod_c [2];
  logic [16:0] rm_c [2];
  logic [16:0] rc_c [2];
  logic [8:0] deg_c [2];

  logic [8:0] deg_r [2];
  logic [15:0] frac_r [2];
  logic vld1_r;
  erg_side_t side1_r;

  logic signed [XW-1:0] av_c [2];
  logic neg_c [2];

  logic signed [XW-1:0] x_r [NST+1][2];
  logic signed [XW-1:0] y_r [NST+1][2];
  logic signed [ZW-1:0] z_r [NST+1][2];
  logic neg_r [NST+1][2];
  logic vld_r [NST+1];
  erg_side_t side_r [NST+1];

  logic signed [XW-1:0] sin_r [2];
  logic signed [XW-1:0] cos_r [2];
  logic vldo_r;
  erg_side_t sideo_r;

  assign ang[0] = in_side.roll;
  assign ang[1] = in_side.pitch;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      u_c[l] = {~ang[l][31], ang[l][30:16]};
      prod_c[l] = 32'(u_c[l]) * 32'd46603;
      rm_c[l] = 17'(u_c[l]) - 17'(prod_c[l][31:24]) * 17'd360;
      rc_c[l] = (rm_c[l] >= 17'd360) ? 17'(rm_c[l] - 17'd360) : rm_c[l];
      deg_c[l] = (rc_c[l] >= 17'd8) ? 9'(rc_c[l] - 17'd8) : 9'(rc_c[l] + 17'd352);
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      av_c[l] = $signed({2'b00, deg_r[l], frac_r[l]});
      neg_c[l] = 1'b0;
      if (av_c[l] >= DEG180_Q16) begin
        av_c[l] = av_c[l] - DEG360_Q16;
      end
      if (av_c[l] > DEG90_Q16) begin
        av_c[l] = DEG180_Q16 - av_c[l];
        neg_c[l] = 1'b1;
      end else if (av_c[l] < -DEG90_Q16) begin
        av_c[l] = -DEG180_Q16 - av_c[l];
        neg_c[l] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      for (int j = 0; j <= NST; j++) begin
        vld_r[j] <= 1'b0;
      end
      vldo_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld_r[0] <= vld1_r;
      for (int j = 1; j <= NST; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
      vldo_r <= vld_r[NST];
    end
  end

  always_ff @(posedge clk) begin
    side1_r <= in_side;
    side_r[0] <= side1_r;
    for (int j = 1; j <= NST; j++) begin
      side_r[j] <= side_r[j-1];
    end
    sideo_r <= side_r[NST];
    for (int l = 0; l < 2; l++) begin
      deg_r[l] <= deg_c[l];
      frac_r[l] <= ang[l][15:0];
      x_r[0][l] <= GAIN_Q24;
      y_r[0][l] <= '0;
      z_r[0][l] <= ZW'(av_c[l]) <<< 8;
      neg_r[0][l] <= neg_c[l];
      for (int j = 1; j <= NST; j++) begin
        neg_r[j][l] <= neg_r[j-1][l];
        if (!z_r[j-1][l][ZW-1]) begin
          x_r[j][l] <= x_r[j-1][l] - (y_r[j-1][l] >>> (j - 1));
          y_r[j][l] <= y_r[j-1][l] + (x_r[j-1][l] >>> (j - 1));
          z_r[j][l] <= z_r[j-1][l] - atan_q24(unsigned'(j - 1));
        end else begin
          x_r[j][l] <= x_r[j-1][l] + (y_r[j-1][l] >>> (j - 1));
          y_r[j][l] <= y_r[j-1][l] - (x_r[j-1][l] >>> (j - 1));
          z_r[j][l] <= z_r[j-1][l] + atan_q24(unsigned'(j - 1));
        end
      end
      sin_r[l] <= y_r[NST][l];
      cos_r[l] <= neg_r[NST][l] ? -x_r[NST][l] : x_r[NST][l];
    end
  end

  assign out_vld = vldo_r;
  assign out_side = sideo_r;
  assign sin_roll = sin_r[0];
  assign cos_roll = cos_r[0];
  assign sin_pitch = sin_r[1];
  assign cos_pitch = cos_r[1];

endmodule
`default_nettype wire

// ----- hdl/erg_div.sv -----
// Body rate mixing products and pipelined restoring division for tangent and secant of pitch.
`default_nettype none
module erg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic signed [erg_pkg::XW-1:0]  sin_roll,
  input  logic signed [erg_pkg::XW-1:0]  cos_roll,
  input  logic signed [erg_pkg::XW-1:0]  sin_pitch,
  input  logic signed [erg_pkg::XW-1:0]  cos_pitch,
  input  erg_pkg::erg_side_t             in_side,
  output logic                           out_vld,
  output logic signed [erg_pkg::TW-1:0]  tan_p,
  output logic signed [erg_pkg::TW-1:0]  sec_p,
  output erg_pkg::erg_kin_t              out_kin
);
  import erg_pkg::*;

  logic [XW-1:0] sabs_c;
  logic [XW-1:0] cabs_c;
  logic [NW-1:0] num_c [2];

  logic signed [59:0] pqs_r, prc_r, pqc_r, prs_r;
  erg_side_t side0_r;
  logic vld0_r;

  logic signed [60:0] suma_c, sumb_c;

  logic [DW-1:0] rem_r [QW+1][2];
  logic [QW-1:0] quo_r [QW+1][2];
  logic [QW-1:0] nlo_r [QW+1][2];
  logic [DW-1:0] den_r [QW+1];
  logic ok_r [QW+1];
  logic sgt_r [QW+1];
  logic sgc_r [QW+1];
  logic vld_r [1:QW];
  erg_kin_t kin_r [1:QW];

  logic [DW:0] trial_c [1:QW][2];

  logic signed [TW-1:0] qt_c, qs_c;
  logic signed [TW-1:0] tan_r, sec_r;
  erg_kin_t kino_r;
  logic vldo_r;

  assign sabs_c = sin_pitch[XW-1] ? XW'(-sin_pitch) : XW'(sin_pitch);
  assign cabs_c = cos_pitch[XW-1] ? XW'(-cos_pitch) : XW'(cos_pitch);
  assign num_c[0] = NW'(sabs_c) << 24;
  assign num_c[1] = SEC_NUM;

  assign suma_c = 61'(pqs_r) + 61'(prc_r);
  assign sumb_c = 61'(pqc_r) - 61'(prs_r);

  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      for (int l = 0; l < 2; l++) begin
        trial_c[k][l] = {rem_r[k-1][l], nlo_r[k-1][l][QW-1]};
      end
    end
  end

  assign qt_c = TW'(quo_r[QW][0]);
  assign qs_c = TW'(quo_r[QW][1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      for (int k = 1; k <= QW; k++) begin
        vld_r[k] <= 1'b0;
      end
      vldo_r <= 1'b0;
    end else begin
      vld0_r <= in_vld;
      vld_r[1] <= vld0_r;
      for (int k = 2; k <= QW; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      vldo_r <= vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    pqs_r <= in_side.q * sin_roll;
    prc_r <= in_side.r * cos_roll;
    pqc_r <= in_side.q * cos_roll;
    prs_r <= in_side.r * sin_roll;
    side0_r <= in_side;
    den_r[0] <= DW'(cabs_c);
    ok_r[0] <= DW'(cabs_c) > COS_EPS_Q24;
    sgt_r[0] <= sin_pitch[XW-1] ^ cos_pitch[XW-1];
    sgc_r[0] <= cos_pitch[XW-1];
    for (int l = 0; l < 2; l++) begin
      rem_r[0][l] <= DW'(num_c[l][NW-1:QW]);
      nlo_r[0][l] <= num_c[l][QW-1:0];
      quo_r[0][l] <= '0;
    end

    kin_r[1].roll <= side0_r.roll;
    kin_r[1].pitch <= side0_r.pitch;
    kin_r[1].yaw <= side0_r.yaw;
    kin_r[1].p <= side0_r.p;
    kin_r[1].dt <= side0_r.dt;
    kin_r[1].a <= AW'(suma_c >>> 24);
    kin_r[1].b <= AW'(sumb_c >>> 24);
    for (int k = 2; k <= QW; k++) begin
      kin_r[k] <= kin_r[k-1];
    end

    for (int k = 1; k <= QW; k++) begin
      den_r[k] <= den_r[k-1];
      ok_r[k] <= ok_r[k-1];
      sgt_r[k] <= sgt_r[k-1];
      sgc_r[k] <= sgc_r[k-1];
      for (int l = 0; l < 2; l++) begin
        nlo_r[k][l] <= nlo_r[k-1][l] << 1;
        if (trial_c[k][l] >= {1'b0, den_r[k-1]}) begin
          rem_r[k][l] <= DW'(trial_c[k][l] - {1'b0, den_r[k-1]});
          quo_r[k][l] <= {quo_r[k-1][l][QW-2:0], 1'b1};
        end else begin
          rem_r[k][l] <= DW'(trial_c[k][l]);
          quo_r[k][l] <= {quo_r[k-1][l][QW-2:0], 1'b0};
        end
      end
    end

    kino_r <= kin_r[QW];
    tan_r <= ok_r[QW] ? (sgt_r[QW] ? -qt_c : qt_c) : '0;
    sec_r <= ok_r[QW] ? (sgc_r[QW] ? -qs_c : qs_c) : '0;
  end

  assign out_vld = vldo_r;
  assign out_kin = kino_r;
  assign tan_p = tan_r;
  assign sec_p = sec_r;

endmodule
`default_nettype wire

// ----- hdl/erg_integ.sv -----
// Euler angle rates, step products and saturated angle update.
`default_nettype none
module erg_integ (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic signed [erg_pkg::TW-1:0]  tan_p,
  input  logic signed [erg_pkg::TW-1:0]  sec_p,
  input  erg_pkg::erg_kin_t              in_kin,
  output logic                           out_vld,
  output logic signed [31:0]             roll_next,
  output logic signed [31:0]             pitch_next,
  output logic signed [31:0]             yaw_next,
  output logic                           skipped
);
  import erg_pkg::*;

  localparam logic signed [PW:0] SAT_MAX = (PW+1)'(64'sd2147483647);
  localparam logic signed [PW:0] SAT_MIN = (PW+1)'(-64'sd2147483648);

  logic signed [17:0] th_c, sh_c;
  logic signed [18:0] tl_c, sl_c;
  logic signed [51:0] pth_r, psh_r;
  logic signed [52:0] ptl_r, psl_r;
  erg_kin_t k0_r;
  logic vld0_r;

  logic signed [71:0] ft_c, fs_c;
  logic signed [PW-1:0] phi_r, psi_r;
  erg_kin_t k1_r;
  logic vld1_r;

  logic signed [24:0] dt_c;
  logic signed [22:0] phh_c, psh_c;
  logic signed [23:0] phl_c, psl_c;
  logic signed [47:0] rh_r, yh_r;
  logic signed [48:0] rl_r, yl_r;
  logic signed [58:0] pb_r;
  logic signed [31:0] roll2_r, pitch2_r, yaw2_r;
  logic skip2_r;
  logic vld2_r;

  logic signed [71:0] fr_c, fy_c;
  logic signed [PW-1:0] dr_r, dp_r, dy_r;
  logic signed [31:0] roll3_r, pitch3_r, yaw3_r;
  logic skip3_r;
  logic vld3_r;

  logic signed [PW:0] sr_c, sp_c, sy_c;
  logic signed [31:0] roll_r, pitch_r, yaw_r;
  logic skip_r;
  logic vld_r;

  function automatic logic signed [31:0] sat32(input logic signed [PW:0] v);
    logic signed [31:0] o;
    if (v > SAT_MAX) begin
      o = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      o = 32'sh80000000;
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

  assign th_c = tan_p[TW-1:18];
  assign tl_c = $signed({1'b0, tan_p[17:0]});
  assign sh_c = sec_p[TW-1:18];
  assign sl_c = $signed({1'b0, sec_p[17:0]});

  assign ft_c = (72'(pth_r) <<< 18) + 72'(ptl_r);
  assign fs_c = (72'(psh_r) <<< 18) + 72'(psl_r);

  assign dt_c = $signed({1'b0, k1_r.dt});
  assign phh_c = phi_r[PW-1:23];
  assign phl_c = $signed({1'b0, phi_r[22:0]});
  assign psh_c = psi_r[PW-1:23];
  assign psl_c = $signed({1'b0, psi_r[22:0]});

  assign fr_c = (72'(rh_r) <<< 23) + 72'(rl_r);
  assign fy_c = (72'(yh_r) <<< 23) + 72'(yl_r);

  assign sr_c = (PW+1)'(roll3_r) + (PW+1)'(dr_r);
  assign sp_c = (PW+1)'(pitch3_r) + (PW+1)'(dp_r);
  assign sy_c = (PW+1)'(yaw3_r) + (PW+1)'(dy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      vld0_r <= in_vld;
      vld1_r <= vld0_r;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    pth_r <= in_kin.a * th_c;
    ptl_r <= in_kin.a * tl_c;
    psh_r <= in_kin.a * sh_c;
    psl_r <= in_kin.a * sl_c;
    k0_r <= in_kin;

    phi_r <= PW'(k0_r.p) + PW'(ft_c >>> 24);
    psi_r <= PW'(fs_c >>> 24);
    k1_r <= k0_r;

    rh_r <= dt_c * phh_c;
    rl_r <= dt_c * phl_c;
    yh_r <= dt_c * psh_c;
    yl_r <= dt_c * psl_c;
    pb_r <= dt_c * k1_r.b;
    roll2_r <= k1_r.roll;
    pitch2_r <= k1_r.pitch;
    yaw2_r <= k1_r.yaw;
    skip2_r <= (k1_r.dt == '0);

    dr_r <= PW'(fr_c >>> 24);
    dp_r <= PW'(pb_r >>> 24);
    dy_r <= PW'(fy_c >>> 24);
    roll3_r <= roll2_r;
    pitch3_r <= pitch2_r;
    yaw3_r <= yaw2_r;
    skip3_r <= skip2_r;

    roll_r <= sat32(sr_c);
    pitch_r <= sat32(sp_c);
    yaw_r <= sat32(sy_c);
    skip_r <= skip3_r;
  end

  assign out_vld = vld_r;
  assign roll_next = roll_r;
  assign pitch_next = pitch_r;
  assign yaw_next = yaw_r;
  assign skipped = skip_r;

endmodule
`default_nettype wire

// ----- hdl/euler_rate_gyro_integrator_top.sv -----
// Top level of the Euler angle rate integrator: command port, configuration register and pipeline.
//
// The block takes one transaction every clock cycle and never raises busy. Each transaction
// returns exactly one result on out_valid, after angle reduction and CORDIC (stage count capped
// at 24), the one-bit-per-stage divider for tangent and secant, and the rate and step products.
// Results are shown for one cycle and cannot be held off. Write yaw_sign_negative only while
// no transaction is in flight.
`default_nettype none
module euler_rate_gyro_integrator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_roll_now,
  input  logic signed [31:0] in_pitch_now,
  input  logic signed [31:0] in_yaw_now,
  input  logic signed [31:0] in_rate_x,
  input  logic signed [31:0] in_rate_y,
  input  logic signed [31:0] in_rate_z,
  input  logic [23:0]        in_step_time,
  output logic               out_valid,
  output logic signed [31:0] out_roll_next,
  output logic signed [31:0] out_pitch_next,
  output logic signed [31:0] out_yaw_next,
  output logic               out_skipped,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import erg_pkg::*;

  logic yaw_neg_r;
  logic in_vld;
  erg_side_t side_c;

  logic c_vld;
  logic signed [XW-1:0] sr, cr, sp, cp;
  erg_side_t c_side;

  logic d_vld;
  logic signed [TW-1:0] tn, sc;
  erg_kin_t d_kin;

  assign busy = 1'b0;
  assign pready = 1'b1;
  assign in_vld = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_neg_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_YAW_SIGN) begin
      yaw_neg_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_YAW_SIGN) ? {31'b0, yaw_neg_r} : '0;

  always_comb begin
    side_c.roll = in_roll_now;
    side_c.pitch = in_pitch_now;
    side_c.yaw = in_yaw_now;
    side_c.p = in_rate_x;
    side_c.q = in_rate_y;
    side_c.r = yaw_neg_r ? -33'(in_rate_z) : 33'(in_rate_z);
    side_c.dt = in_step_time;
  end

  erg_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_vld),
    .in_side   (side_c),
    .out_vld   (c_vld),
    .sin_roll  (sr),
    .cos_roll  (cr),
    .sin_pitch (sp),
    .cos_pitch (cp),
    .out_side  (c_side)
  );

  erg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (c_vld),
    .sin_roll  (sr),
    .cos_roll  (cr),
    .sin_pitch (sp),
    .cos_pitch (cp),
    .in_side   (c_side),
    .out_vld   (d_vld),
    .tan_p     (tn),
    .sec_p     (sc),
    .out_kin   (d_kin)
  );

  erg_integ u_integ (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (d_vld),
    .tan_p      (tn),
    .sec_p      (sc),
    .in_kin     (d_kin),
    .out_vld    (out_valid),
    .roll_next  (out_roll_next),
    .pitch_next (out_pitch_next),
    .yaw_next   (out_yaw_next),
    .skipped    (out_skipped)
  );

endmodule
`default_nettype wire

// ----- test/tb_euler_rate_gyro_integrator_top.sv -----
// Self-checking testbench for the Euler angle rate integrator: directed table, random bursts.
`default_nettype none
module tb_euler_rate_gyro_integrator_top;
  import erg_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;
  localparam longint DEG90 = 64'sd5898240;
  localparam longint DEG180 = 64'sd11796480;
  localparam longint DEG360 = 64'sd23592960;
  localparam longint UNIT_Q24 = 64'sd16777216;
  localparam longint XGAIN = 64'sd10188013;
  localparam longint COS_FLOOR = 64'sd16777;
  localparam longint ATAN_DEG[24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115};

  typedef struct {
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
    logic signed [31:0] p;
    logic signed [31:0] q;
    logic signed [31:0] r;
    logic [23:0] dt;
  } attitude_t;

  typedef struct {
    logic [31:0] roll;
    logic [31:0] pitch;
    logic [31:0] yaw;
    logic skipped;
  } angles_t;

  typedef struct {
    attitude_t stim;
    bit typed;
    angles_t want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic signed [31:0] in_roll_now = '0;
  logic signed [31:0] in_pitch_now = '0;
  logic signed [31:0] in_yaw_now = '0;
  logic signed [31:0] in_rate_x = '0;
  logic signed [31:0] in_rate_y = '0;
  logic signed [31:0] in_rate_z = '0;
  logic [23:0] in_step_time = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire busy;
  wire out_valid;
  wire signed [31:0] out_roll_next;
  wire signed [31:0] out_pitch_next;
  wire signed [31:0] out_yaw_next;
  wire out_skipped;
  wire [31:0] prdata;
  wire pready;

  angles_t pending_angles[$];
  bit yaw_negate = 1'b0;
  int fail_count = 0;
  int idle_cycles = 0;

  euler_rate_gyro_integrator_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_roll_now(in_roll_now), .in_pitch_now(in_pitch_now), .in_yaw_now(in_yaw_now),
    .in_rate_x(in_rate_x), .in_rate_y(in_rate_y), .in_rate_z(in_rate_z),
    .in_step_time(in_step_time),
    .out_valid(out_valid), .out_roll_next(out_roll_next), .out_pitch_next(out_pitch_next),
    .out_yaw_next(out_yaw_next), .out_skipped(out_skipped),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint scale_q24(input longint a, input longint b);
    longint bh, bl;
    bh = b >>> 24;
    bl = b - (bh <<< 24);
    return a * bh + ((a * bl) >>> 24);
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic void cordic_sin_cos(input longint ang, output longint s, output longint c);
    longint a, x, y, z, dx, dy;
    bit flip;
    a = ((ang % DEG360) + DEG360) % DEG360;
    flip = 1'b0;
    x = XGAIN;
    y = 0;
    if (a >= DEG180) a -= DEG360;
    if (a > DEG90) begin
      a = DEG180 - a;
      flip = 1'b1;
    end else if (a < -DEG90) begin
      a = -DEG180 - a;
      flip = 1'b1;
    end
    z = a * 256;
    for (int i = 0; i < NST; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_DEG[i];
      end else begin
        x += dx; y -= dy; z += ATAN_DEG[i];
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic angles_t integrate_angles(input attitude_t it, input bit negate_z);
    longint roll, pitch, yaw, p, q, r, dt, sr, cr, sp, cp, tn, sc, a, b, cabs;
    angles_t res;
    roll = it.roll; pitch = it.pitch; yaw = it.yaw;
    p = it.p; q = it.q; r = it.r;
    dt = longint'(it.dt);
    if (dt == 0) begin
      res.roll = it.roll; res.pitch = it.pitch; res.yaw = it.yaw; res.skipped = 1'b1;
      return res;
    end
    if (negate_z) r = -r;
    cordic_sin_cos(roll, sr, cr);
    cordic_sin_cos(pitch, sp, cp);
    cabs = (cp < 0) ? -cp : cp;
    tn = 0;
    sc = 0;
    if (cabs > COS_FLOOR) begin
      tn = (sp * UNIT_Q24) / cp;
      sc = (UNIT_Q24 * UNIT_Q24) / cp;
    end
    a = (q * sr + r * cr) >>> 24;
    b = (q * cr - r * sr) >>> 24;
    res.roll = clamp32(roll + scale_q24(dt, p + scale_q24(a, tn)));
    res.pitch = clamp32(pitch + scale_q24(dt, b));
    res.yaw = clamp32(yaw + scale_q24(dt, scale_q24(a, sc)));
    res.skipped = 1'b0;
    return res;
  endfunction

  // Issues one transaction and records what it must produce once it is taken.
  task automatic send_step(input attitude_t it, input bit typed, input angles_t want);
    start <= 1'b1;
    in_roll_now <= it.roll;
    in_pitch_now <= it.pitch;
    in_yaw_now <= it.yaw;
    in_rate_x <= it.p;
    in_rate_y <= it.q;
    in_rate_z <= it.r;
    in_step_time <= it.dt;
    do @(posedge clk); while (busy);
    pending_angles.push_back(typed ? want : integrate_angles(it, yaw_negate));
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    do @(posedge clk); while (pending_angles.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (wr && addr == 3'(4 * REG_YAW_SIGN)) yaw_negate = data[0];
  endtask

  task automatic cfg_write_and_check(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] rd;
    cfg_access(1'b1, addr, data, rd);
    @(posedge clk);
    cfg_access(1'b0, 3'(4 * REG_YAW_SIGN), '0, rd);
    if (rd[0] !== yaw_negate) begin
      $error("yaw_sign_negative readback expected %0d actual %0d", yaw_negate, rd[0]);
      fail_count++;
    end
    @(posedge clk);
  endtask

  function automatic attitude_t random_attitude();
    attitude_t it;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode <= 1) begin
      it.roll = $urandom; it.pitch = $urandom; it.yaw = $urandom;
      it.p = $urandom; it.q = $urandom; it.r = $urandom;
      it.dt = 24'($urandom);
    end else begin
      it.roll = $signed($urandom_range(0, 2 * 23592960)) - 23592960;
      it.pitch = $signed($urandom_range(0, 2 * 23592960)) - 23592960;
      it.yaw = $urandom;
      it.p = $signed($urandom_range(0, 2 * 32768000)) - 32768000;
      it.q = $signed($urandom_range(0, 2 * 32768000)) - 32768000;
      it.r = $signed($urandom_range(0, 2 * 32768000)) - 32768000;
      it.dt = 24'($urandom_range(1, 1000000));
      if (mode == 2) it.pitch = ($urandom_range(0, 1) ? 5898240 : -5898240)
                                + $signed($urandom_range(0, 200)) - 100;
    end
    if ($urandom_range(0, 14) == 0) it.dt = '0;
    return it;
  endfunction

  task automatic random_bursts(input int count);
    int sent;
    angles_t none;
    none = '{default: '0};
    sent = 0;
    while (sent < count) begin
      int burst;
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_step(random_attitude(), 1'b0, none);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  step_row_t step_table[$];

  function automatic attitude_t mk(input logic [31:0] roll, pitch, yaw, p, q, r,
                                   input logic [23:0] dt);
    attitude_t it;
    it.roll = roll; it.pitch = pitch; it.yaw = yaw;
    it.p = p; it.q = q; it.r = r; it.dt = dt;
    return it;
  endfunction

  initial begin
    angles_t none;
    logic [31:0] dummy;
    none = '{default: '0};
    step_table = '{
      '{mk(0, 0, 0, 0, 0, 0, 0), 1'b1, '{32'h0, 32'h0, 32'h0, 1'b1}},
      '{mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
           32'h7fffffff, 0), 1'b1, '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1}},
      '{mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
           32'h80000000, 0), 1'b1, '{32'h80000000, 32'h80000000, 32'h80000000, 1'b1}},
      '{mk(32'h7fffffff, 0, 0, 32'h7fffffff, 0, 0, 24'hffffff), 1'b1,
        '{32'h7fffffff, 32'h0, 32'h0, 1'b0}},
      '{mk(32'h80000000, 0, 0, 32'h80000000, 0, 0, 24'hffffff), 1'b1,
        '{32'h80000000, 32'h0, 32'h0, 1'b0}},
      '{mk(0, 5898240, 0, 65536, 65536 * 30, 65536 * 20, 24'h100000), 1'b0, none},
      '{mk(0, -5898240, 0, 65536, 65536 * 30, 65536 * 20, 24'h100000), 1'b0, none},
      '{mk(0, 5898240 + 30, 0, 65536 * 5, 65536 * 30, 65536 * 20, 24'h100000), 1'b0, none},
      '{mk(11796480, 0, 0, 65536 * 10, 65536 * 40, -65536 * 25, 24'h080000), 1'b0, none},
      '{mk(-11796480, 0, 0, 65536 * 10, 65536 * 40, -65536 * 25, 24'h080000), 1'b0, none},
      '{mk(17694720, 2949120, 0, 0, 65536 * 40, 65536 * 40, 24'h080000), 1'b0, none},
      '{mk(23592960, -2949120, 0, 0, -65536 * 40, 65536 * 40, 24'h080000), 1'b0, none},
      '{mk(2949120, 2949120, 32'h7fff0000, 0, 32'h7fffffff, 32'h7fffffff, 24'hffffff),
        1'b0, none},
      '{mk(-2949120, -2949120, 32'h80010000, 0, 32'h80000000, 32'h80000000, 24'hffffff),
        1'b0, none},
      '{mk(32'h7fffffff, 32'h7fffffff, 0, 32'h80000000, 32'h7fffffff, 32'h80000000,
           24'hffffff), 1'b0, none},
      '{mk(1966080, 1310720, 65536, 65536, -65536, 65536 * 3, 24'h000001), 1'b0, none}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (step_table[i]) send_step(step_table[i].stim, step_table[i].typed, step_table[i].want);
    random_bursts(150);
    drain_pipeline();
    cfg_write_and_check(3'(4 * REG_YAW_SIGN), 32'h1);
    foreach (step_table[i]) if (!step_table[i].typed) send_step(step_table[i].stim, 1'b0, none);
    random_bursts(100);
    start <= 1'b0;
    wait (pending_angles.size() == 0);
    @(posedge clk);
    random_bursts(100);
    drain_pipeline();
    cfg_write_and_check(3'(4 * REG_YAW_SIGN), 32'hfffffffe);
    cfg_access(1'b1, 3'd4, 32'h1, dummy);
    @(posedge clk);
    random_bursts(220);
    drain_pipeline();
    cfg_write_and_check(3'(4 * REG_YAW_SIGN), 32'h3);
    random_bursts(220);
    drain_pipeline();
    if (fail_count == 0) begin
      $display("euler_rate_gyro_integrator_top verification clean");
    end else begin
      $display("euler_rate_gyro_integrator_top verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_angles.size() == 0) begin
        $error("result transaction with no expectation pending");
        fail_count++;
      end else begin
        angles_t want;
        want = pending_angles.pop_front();
        if (out_roll_next !== want.roll) begin
          $error("roll_next expected %0d actual %0d", $signed(want.roll), out_roll_next);
          fail_count++;
        end
        if (out_pitch_next !== want.pitch) begin
          $error("pitch_next expected %0d actual %0d", $signed(want.pitch), out_pitch_next);
          fail_count++;
        end
        if (out_yaw_next !== want.yaw) begin
          $error("yaw_next expected %0d actual %0d", $signed(want.yaw), out_yaw_next);
          fail_count++;
        end
        if (out_skipped !== want.skipped) begin
          $error("skipped expected %0d actual %0d", want.skipped, out_skipped);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("euler_rate_gyro_integrator_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/erg_pkg.sv
hdl/erg_cordic.sv
hdl/erg_div.sv
hdl/erg_integ.sv
hdl/euler_rate_gyro_integrator_top.sv
test/tb_euler_rate_gyro_integrator_top.sv
